>>> design/sdf_pkg.sv
// shared types and constants for the stream duplicate filter
`timescale 1ns / 1ps

package sdf_pkg;

   localparam int DATA_W  = 32;
   localparam int COUNT_W = 7;

   // input beat
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } sdf_req_type;

   // result beat
   typedef struct packed {
      logic signed [DATA_W-1:0] value_out;
      logic                     keep;
      logic [COUNT_W-1:0]       distinct_count;
      logic                     set_end;
      logic                     overflow;
   } sdf_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } sdf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic out_free;
   } sdf_sts_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } sdf_state_type;

endpackage

>>> design/stream_duplicate_filter.sv
// Stream duplicate filter: flags first occurrences of values within a set.
// Each input beat carries one signed value and a last-of-set mark. The value is
// compared against the distinct values already held for the set, one stored
// entry per cycle through the single read port of the store. The store holds
// at most DEPTH distinct values of the set; the scan reads the ones stored so
// far and stops early at the first match. A new value is
// written to the store and reported with keep set; a repeat has keep clear.
// When the store already holds DEPTH values, a new value is not stored and is
// reported with overflow set. distinct_count gives the stored count after this
// beat, modulo 128. The store empties after the beat marked last. The next
// input beat is taken while a finished result still waits on the output.
`timescale 1ns / 1ps

module stream_duplicate_filter import sdf_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  sdf_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output sdf_rsp_type rsp_data
);

   sdf_cmd_type cmd;
   sdf_sts_type sts;

   // controller
   sdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath
   sdf_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .sts       (sts)
   );

`ifndef SYNTHESIS
   // a result is only committed into a free output register
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sts.out_free)
      else $error("commit while output register occupied");

   // at most one command at a time
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.scan, cmd.commit}))
      else $error("conflicting controller commands");

   // one item in flight: no new beat straight after an accepted one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while an item is in progress");

   // a commit always presents a result beat
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("committed result not presented");
`endif

endmodule

>>> design/sdf_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module sdf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/sdf_datapath.sv
// datapath: store scan, compare, count and result register
`timescale 1ns / 1ps

module sdf_datapath import sdf_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  sdf_cmd_type cmd,
   input  sdf_req_type req_data,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output sdf_rsp_type rsp_data,
   output sdf_sts_type sts
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   sdf_req_type    item_ff, item_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  issue_idx_ff, issue_idx_in;
   logic           cmp_valid_ff, cmp_valid_in;
   logic           hit_ff, hit_in;
   logic           rsp_valid_ff, rsp_valid_in;
   sdf_rsp_type    rsp_data_ff, rsp_data_in;

   logic              issue_go;
   logic              hit_now;
   logic              is_new;
   logic              full;
   logic              wr_en;
   logic [CW-1:0]     count_after;
   logic [DATA_W-1:0] rd_data;

   sdf_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (item_ff.value),
      .rd_en   (issue_go),
      .rd_addr (issue_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // scan: one read issued per cycle, compared when the registered read data returns
   always_comb begin
      issue_go     = cmd.scan && (issue_idx_ff != count_ff);
      hit_now      = cmp_valid_ff && (rd_data == item_ff.value);
      cmp_valid_in = issue_go;
      if (cmd.load) begin
         issue_idx_in = '0;
      end else if (issue_go) begin
         issue_idx_in = issue_idx_ff + CW'(1);
      end else begin
         issue_idx_in = issue_idx_ff;
      end
      hit_in = cmd.load ? 1'b0 : (hit_ff | hit_now);
   end

   // decision, store write and count update
   always_comb begin
      is_new      = !hit_ff;
      full        = (count_ff == FULL_COUNT);
      wr_en       = cmd.commit && is_new && !full;
      count_after = wr_en ? (count_ff + CW'(1)) : count_ff;
      if (cmd.commit) begin
         count_in = item_ff.last ? '0 : count_after;
      end else begin
         count_in = count_ff;
      end
      item_in = cmd.load ? req_data : item_ff;
   end

   // result register
   always_comb begin
      sts.out_free  = !rsp_valid_ff || rsp_ready;
      sts.scan_done = hit_now || ((issue_idx_ff == count_ff) && !cmp_valid_ff);
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_data_in = rsp_data_ff;
      if (cmd.commit) begin
         rsp_data_in.value_out      = item_ff.value;
         rsp_data_in.keep           = is_new && !full;
         rsp_data_in.distinct_count = COUNT_W'(count_after);
         rsp_data_in.set_end        = item_ff.last;
         rsp_data_in.overflow       = is_new && full;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         issue_idx_ff <= '0;
         cmp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         issue_idx_ff <= issue_idx_in;
         cmp_valid_ff <= cmp_valid_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> design/sdf_ctrl.sv
// controller state machine: accept, scan, commit
`timescale 1ns / 1ps

module sdf_ctrl import sdf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  sdf_sts_type sts,
   output sdf_cmd_type cmd
);

   sdf_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
